FILE: design/mec_pkg.sv
// Package for the multiset equality checker.
// Holds table sizes, count limits, the entry layout, epoch and controller state types, and the key hash.
// No dependencies.
package mec_pkg;

  localparam int ENTRIES = 256;
  localparam int COUNT_WIDTH = 18;
  localparam int KEY_W = 32;
  localparam int SLOT_W = 2;
  localparam int EPOCH_W = 4;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USE_W = $clog2(ENTRIES + 1);
  localparam int MEM_W = EPOCH_W + SLOT_W + KEY_W + COUNT_WIDTH;
  localparam int HASH_CHUNKS = (KEY_W + IDX_W - 1) / IDX_W;

  typedef logic signed [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  localparam cnt_t CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam cnt_t CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST = '1;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_EMPTY,
    SLOT_LIVE,
    SLOT_DEAD
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CLEAR
  } ctrl_state_t;

  typedef struct packed {
    logic valid;
    logic equal;
    logic overflow;
  } result_t;

  function automatic logic [IDX_W-1:0] key_hash(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0] w;
    h = '0;
    for (int i = 0; i < HASH_CHUNKS; i++) begin
      h = h ^ IDX_W'(k >> (i * IDX_W));
    end
    w = {1'b0, h};
    if (w >= (IDX_W+1)'(ENTRIES)) begin
      w = w - (IDX_W+1)'(ENTRIES);
    end
    return w[IDX_W-1:0];
  endfunction

endpackage

FILE: design/mec_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module mec_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mec_ctrl.sv
// Probe controller: hashes the key, walks the table with linear probing,
// updates counts and slot status, forms the verdict, and clears the table. Depends on mec_pkg.
module mec_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        func,
  input  logic signed [31:0]          value,
  input  logic                        last,
  output logic                        busy,
  output logic [mec_pkg::IDX_W-1:0]   rd_addr,
  input  logic [mec_pkg::MEM_W-1:0]   rd_data,
  output logic                        wr_en,
  output logic [mec_pkg::IDX_W-1:0]   wr_addr,
  output logic [mec_pkg::MEM_W-1:0]   wr_data,
  output mec_pkg::result_t            res
);

  mec_pkg::ctrl_state_t state, state_next;

  logic [mec_pkg::KEY_W-1:0] key;
  logic down;
  logic is_last;
  logic [mec_pkg::IDX_W-1:0] probe, probe_next, probe_step;
  logic [mec_pkg::USE_W-1:0] probes, probes_next;
  logic free_found, free_found_next;
  logic [mec_pkg::IDX_W-1:0] free_idx, free_idx_next;
  logic [mec_pkg::USE_W-1:0] in_use, in_use_next;
  logic ovf, ovf_next;
  mec_pkg::epoch_t epoch, epoch_next;
  logic accept;
  mec_pkg::slot_t st_val;
  logic clear_all;

  mec_pkg::slot_t cur;
  mec_pkg::slot_t rd_slot;
  mec_pkg::epoch_t rd_epoch;
  logic [mec_pkg::KEY_W-1:0] rd_key;
  mec_pkg::cnt_t rd_count, cnt_new;
  mec_pkg::epoch_t wr_epoch;
  logic [mec_pkg::KEY_W-1:0] wr_key;
  logic [mec_pkg::IDX_W-1:0] ins_idx;
  logic wrapped;

  assign rd_epoch = rd_data[mec_pkg::MEM_W-1 -: mec_pkg::EPOCH_W];
  assign rd_slot = mec_pkg::slot_t'(
    rd_data[mec_pkg::KEY_W+mec_pkg::COUNT_WIDTH +: mec_pkg::SLOT_W]);
  assign rd_key = rd_data[mec_pkg::COUNT_WIDTH +: mec_pkg::KEY_W];
  assign rd_count = rd_data[mec_pkg::COUNT_WIDTH-1:0];
  assign cur = (rd_epoch == epoch) ? rd_slot : mec_pkg::SLOT_EMPTY;
  assign busy = (state != mec_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign probe_step = (probe == mec_pkg::IDX_W'(mec_pkg::ENTRIES - 1)) ? '0 : probe + 1'b1;
  assign wrapped = (probes == mec_pkg::USE_W'(mec_pkg::ENTRIES - 1));
  assign ins_idx = free_found ? free_idx : probe;
  assign wr_data = {wr_epoch, st_val, wr_key, cnt_new};

  always_comb begin
    state_next = state;
    probe_next = probe;
    probes_next = probes;
    free_found_next = free_found;
    free_idx_next = free_idx;
    in_use_next = in_use;
    ovf_next = ovf;
    epoch_next = epoch;
    rd_addr = probe_step;
    wr_en = 1'b0;
    wr_addr = probe;
    wr_epoch = epoch;
    wr_key = key;
    st_val = mec_pkg::SLOT_LIVE;
    cnt_new = rd_count;
    clear_all = 1'b0;
    res = '0;
    case (state)
      mec_pkg::ST_IDLE: begin
        rd_addr = mec_pkg::key_hash($unsigned(value));
        if (accept) begin
          state_next = mec_pkg::ST_PROBE;
          probe_next = rd_addr;
          probes_next = '0;
          free_found_next = 1'b0;
        end
      end
      mec_pkg::ST_PROBE: begin
        if (cur == mec_pkg::SLOT_LIVE && rd_key == key) begin
          state_next = mec_pkg::ST_IDLE;
          if (down && rd_count == mec_pkg::CNT_MIN) begin
            ovf_next = 1'b1;
          end else if (!down && rd_count == mec_pkg::CNT_MAX) begin
            ovf_next = 1'b1;
          end else begin
            cnt_new = down ? rd_count - 1'b1 : rd_count + 1'b1;
            wr_en = 1'b1;
            if (cnt_new == '0) begin
              st_val = mec_pkg::SLOT_DEAD;
              in_use_next = in_use - 1'b1;
            end
          end
        end else if (cur == mec_pkg::SLOT_EMPTY || wrapped) begin
          state_next = mec_pkg::ST_IDLE;
          if (free_found || cur != mec_pkg::SLOT_LIVE) begin
            cnt_new = down ? '1 : mec_pkg::cnt_t'(1);
            wr_en = 1'b1;
            wr_addr = ins_idx;
            st_val = mec_pkg::SLOT_LIVE;
            in_use_next = in_use + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end else begin
          probe_next = probe_step;
          probes_next = probes + 1'b1;
          if (!free_found && cur == mec_pkg::SLOT_DEAD) begin
            free_found_next = 1'b1;
            free_idx_next = probe;
          end
        end
        if (state_next == mec_pkg::ST_IDLE && is_last) begin
          res.valid = 1'b1;
          res.equal = (in_use_next == '0) && !ovf_next;
          res.overflow = ovf_next;
          clear_all = 1'b1;
          if (epoch == mec_pkg::EPOCH_LAST) begin
            state_next = mec_pkg::ST_CLEAR;
            probe_next = '0;
          end else begin
            epoch_next = epoch + 1'b1;
          end
        end
      end
      mec_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        wr_epoch = '0;
        wr_key = '0;
        st_val = mec_pkg::SLOT_EMPTY;
        cnt_new = '0;
        probe_next = probe_step;
        if (probe == mec_pkg::IDX_W'(mec_pkg::ENTRIES - 1)) begin
          state_next = mec_pkg::ST_IDLE;
          epoch_next = mec_pkg::EPOCH_FIRST;
        end
      end
      default: begin
        state_next = mec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mec_pkg::ST_CLEAR;
      probe <= '0;
      epoch <= '0;
    end else begin
      state <= state_next;
      probe <= probe_next;
      epoch <= epoch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      in_use <= '0;
      ovf <= 1'b0;
    end else begin
      in_use <= in_use_next;
      ovf <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= $unsigned(value);
      down <= func;
      is_last <= last;
    end
    probes <= probes_next;
    free_found <= free_found_next;
    free_idx <= free_idx_next;
  end

endmodule

FILE: design/multiset_equality_check.sv
// Top level of the multiset equality checker.
// Instantiates the table RAM and the probe controller; registers the verdict.
// Depends on mec_pkg, mec_ram and mec_ctrl.

// Each item is taken when start is high and busy is low. The accepting cycle
// reads its hashed entry; the linear probe walk then visits entries of the
// 256-entry key/count RAM until one entry decides or the walk has gone all
// the way around. The verdict for an item marked last appears on equal and
// overflow with strobe high for exactly one cycle, in the cycle after that
// item finishes; it must be captured then, as it cannot be held off. Every
// entry carries an epoch mark, and a pair is cleared by advancing the epoch
// in the verdict cycle. After reset, and after every fifteenth verdict when
// the epoch runs out, busy stays high for a clearing pass that rewrites every
// entry.
module multiset_equality_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               busy,
  output logic               strobe,
  output logic               equal,
  output logic               overflow
);

  logic [mec_pkg::IDX_W-1:0] rd_addr;
  logic [mec_pkg::MEM_W-1:0] rd_data;
  logic wr_en;
  logic [mec_pkg::IDX_W-1:0] wr_addr;
  logic [mec_pkg::MEM_W-1:0] wr_data;
  mec_pkg::result_t res;

  mec_ram #(
    .DEPTH(mec_pkg::ENTRIES),
    .WIDTH(mec_pkg::MEM_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  mec_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .value  (value),
    .last   (last),
    .busy   (busy),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      equal <= res.equal;
      overflow <= res.overflow;
    end
  end

`ifndef SYNTHESIS
  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("verdict without an item in progress");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(equal && overflow))
    else $error("equal reported together with overflow");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start a probe");
`endif

endmodule

FILE: verif/tb_multiset_equality_check.sv
// Testbench for multiset_equality_check: streams pairs of arrays and checks each verdict
// against a scoreboard that keeps its own bounded count table.
// Depends on mec_pkg and multiset_equality_check.
module tb_multiset_equality_check;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 220;

  typedef struct packed {
    logic        down;
    logic [31:0] val;
  } elem_t;

  class verdict_board;
    logic [31:0]   keys[mec_pkg::ENTRIES];
    mec_pkg::cnt_t tally[mec_pkg::ENTRIES];
    bit            held[mec_pkg::ENTRIES];
    int unsigned   in_use;
    bit            spilled;
    logic [1:0]    verdicts[$];
    int unsigned   errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (held[i]) held[i] = 1'b0;
      in_use = 0;
      spilled = 1'b0;
    endfunction

    function void note_item(logic down, logic [31:0] key, logic fin);
      int            hit;
      int            slot;
      mec_pkg::cnt_t c;
      hit = -1;
      slot = -1;
      for (int i = 0; i < mec_pkg::ENTRIES; i++) begin
        if (held[i]) begin
          if (hit < 0 && keys[i] == key) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (hit >= 0) begin
        c = tally[hit];
        if (down ? (c == mec_pkg::CNT_MIN) : (c == mec_pkg::CNT_MAX)) begin
          spilled = 1'b1;
        end else begin
          c = down ? mec_pkg::cnt_t'(c - 1) : mec_pkg::cnt_t'(c + 1);
          if (c == 0) begin
            held[hit] = 1'b0;
            in_use--;
          end else begin
            tally[hit] = c;
          end
        end
      end else if (slot < 0) begin
        spilled = 1'b1;
      end else begin
        keys[slot] = key;
        tally[slot] = down ? mec_pkg::cnt_t'(-1) : mec_pkg::cnt_t'(1);
        held[slot] = 1'b1;
        in_use++;
      end
      if (fin) begin
        verdicts.push_back({in_use == 0 && !spilled, spilled});
        wipe();
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic eq, logic of);
      logic [1:0] want;
      if (verdicts.size() == 0) begin
        report($sformatf("result with none pending: equal=%0b overflow=%0b", eq, of));
      end else begin
        want = verdicts.pop_front();
        if (eq !== want[1]) report($sformatf("equal=%0b, predicted %0b", eq, want[1]));
        if (of !== want[0]) report($sformatf("overflow=%0b, predicted %0b", of, want[0]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic [31:0] value = '0;
  logic        last = 1'b0;
  logic        busy;
  logic        strobe;
  logic        equal;
  logic        overflow;

  verdict_board board;
  logic [31:0]  bases[4];
  bit           steady = 1'b0;
  int unsigned  cycles = 0;

  multiset_equality_check u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .func(func),
    .value(value),
    .last(last),
    .busy(busy),
    .strobe(strobe),
    .equal(equal),
    .overflow(overflow)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) board.check_result(equal, overflow);
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] m;
    logic [31:0] v;
    m = $urandom_range(0, 255);
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 15) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: begin
        // Neighbors of a few base values that differ by the same byte in two places.
        v = bases[$urandom_range(0, 3)] ^
            ($urandom_range(0, 1) ? (m | (m << 8)) : ((m << 16) | (m << 24)));
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input logic f, input logic [31:0] v, input logic fin);
    while (!steady && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    value <= v;
    last <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(f, v, fin);
  endtask

  task automatic send_seq(input elem_t s[$]);
    for (int i = 0; i < s.size(); i++) send_item(s[i].down, s[i].val, i == s.size() - 1);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (board.verdicts.size() != 0);
  endtask

  initial begin
    elem_t       seq[$];
    logic [31:0] pool_a[$];
    logic [31:0] pool_b[$];
    logic [31:0] keys[8];
    int          net[8];
    logic [31:0] tmp;
    logic [31:0] base;
    int          n;
    int          j;
    int          k;
    int          pick;
    int          bias;
    int          sent;
    int          pair_no;

    board = new();
    foreach (bases[i]) bases[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_item(1'b0, 32'h0000_0000, 1'b1);
    send_item(1'b0, 32'h7FFF_FFFF, 1'b0);
    send_item(1'b1, 32'h7FFF_FFFF, 1'b1);
    send_item(1'b1, 32'h8000_0000, 1'b0);
    send_item(1'b0, 32'h8000_0000, 1'b1);
    send_item(1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b1, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b1, 32'h0000_0005, 1'b1);
    send_item(1'b0, 32'h0000_0001, 1'b0);
    send_item(1'b0, 32'h0000_0101, 1'b0);
    send_item(1'b1, 32'h0000_0101, 1'b0);
    send_item(1'b1, 32'h0000_0001, 1'b1);
    send_item(1'b0, 32'h0000_0007, 1'b0);
    send_item(1'b0, 32'h0000_0007, 1'b0);
    send_item(1'b1, 32'h0000_0007, 1'b1);
    send_item(1'b1, 32'h5555_5555, 1'b0);
    send_item(1'b1, 32'hAAAA_AAAA, 1'b0);
    send_item(1'b0, 32'hAAAA_AAAA, 1'b0);
    send_item(1'b0, 32'h5555_5555, 1'b1);
    wait_drained();

    // Fill the table, free one entry and reuse it, offer one key too many, then empty it.
    base = $urandom;
    for (int i = 0; i < mec_pkg::ENTRIES; i++) send_item(1'b0, base + i * 32'h9E37_79B9, 1'b0);
    send_item(1'b1, base, 1'b0);
    send_item(1'b0, base + mec_pkg::ENTRIES * 32'h9E37_79B9, 1'b0);
    send_item(1'b0, base + (mec_pkg::ENTRIES + 1) * 32'h9E37_79B9, 1'b0);
    for (int i = 1; i <= mec_pkg::ENTRIES; i++)
      send_item(1'b1, base + i * 32'h9E37_79B9, i == mec_pkg::ENTRIES);
    wait_drained();

    sent = 0;
    pair_no = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (pair_no >= 4 && pair_no < 10);
      seq.delete();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pool_a.delete();
        n = $urandom_range(1, 12);
        repeat (n) begin
          if (pool_a.size() != 0 && $urandom_range(0, 2) == 0)
            pool_a.push_back(pool_a[$urandom_range(0, pool_a.size() - 1)]);
          else
            pool_a.push_back(pick_value());
        end
        pool_b = pool_a;
        for (int i = pool_b.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = pool_b[i];
          pool_b[i] = pool_b[j];
          pool_b[j] = tmp;
        end
        case ($urandom_range(0, 3))
          2: pool_b[$urandom_range(0, pool_b.size() - 1)] = pick_value();
          3: begin
            if ($urandom_range(0, 1)) void'(pool_b.pop_back());
            else pool_b.push_back(pick_value());
          end
          default: ;
        endcase
        bias = $urandom_range(10, 90);
        while (pool_a.size() != 0 || pool_b.size() != 0) begin
          if (pool_b.size() == 0 || (pool_a.size() != 0 && $urandom_range(0, 99) < bias))
            seq.push_back('{1'b0, pool_a.pop_front()});
          else
            seq.push_back('{1'b1, pool_b.pop_front()});
        end
      end else if (pick < 85) begin
        // Repeated insert and release of a few keys, often balanced at the end.
        k = $urandom_range(2, 8);
        for (int i = 0; i < k; i++) begin
          keys[i] = pick_value();
          net[i] = 0;
        end
        n = $urandom_range(6, 30);
        repeat (n) begin
          pick = $urandom_range(0, k - 1);
          j = $urandom_range(0, 1);
          seq.push_back('{j[0], keys[pick]});
          net[pick] += j ? -1 : 1;
        end
        if ($urandom_range(0, 1)) begin
          for (int i = 0; i < k; i++) begin
            while (net[i] > 0) begin
              seq.push_back('{1'b1, keys[i]});
              net[i]--;
            end
            while (net[i] < 0) begin
              seq.push_back('{1'b0, keys[i]});
              net[i]++;
            end
          end
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          j = $urandom_range(0, 1);
          seq.push_back('{j[0], pick_value()});
        end
      end
      send_seq(seq);
      sent += seq.size();
      pair_no++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    steady = 1'b0;
    wait_drained();
    repeat (mec_pkg::ENTRIES + 8) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/mec_pkg.sv
design/mec_ram.sv
design/mec_ctrl.sv
design/multiset_equality_check.sv
verif/tb_multiset_equality_check.sv
